/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. They compile to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property holds at every edge outside reset
`define ASSERT_AR(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_AR(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/rme_pkg.sv */
// ----------------------------------------------------------------------------
// rme_pkg
// Types and constants of the modular exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none

package rme_pkg;

	// configuration register index
	typedef logic [1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_MODULUS  = 2'd0;
	localparam cfg_idx_t CFG_PUB_EXP  = 2'd1;
	localparam cfg_idx_t CFG_PRIV_EXP = 2'd2;

	// action codes
	localparam logic ACT_ENCRYPT = 1'b0;
	localparam logic ACT_DECRYPT = 1'b1;

	// exponentiation sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED,
		ST_SQ,
		ST_MUL,
		ST_FIN
	} st_t;

	// handshake between sequencer and modular multiplier
	typedef struct packed {
		logic start;
	} mm_req_t;

	typedef struct packed {
		logic done;
		logic busy;
	} mm_rsp_t;

endpackage

`default_nettype wire

/* hdl/rme_mulmod.sv */
// ----------------------------------------------------------------------------
// rme_mulmod
// Shift-add modular multiplier: one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rme_mulmod #(
	parameter int W = 24
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rme_pkg::mm_req_t  req,
	output rme_pkg::mm_rsp_t       rsp,
	input  wire logic [W-1:0]      a,
	input  wire logic [W-1:0]      b,
	input  wire logic [W-1:0]      m,
	output logic [W-1:0]           prod
);

	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;

	logic [W+1:0]  sum;
	logic [W+1:0]  m1;
	logic [W+1:0]  m2;
	logic [W+1:0]  sub1;
	logic [W+1:0]  sub2;
	logic [W-1:0]  step;

	// acc = 2*acc + bit*a, then fold back below m (sum is under 3m)
	always_comb begin
		sum  = {1'b0, acc_q, 1'b0} + {2'b00, (a_q & {W{b_q[W-1]}})};
		m1   = {2'b00, m};
		m2   = {1'b0, m, 1'b0};
		sub1 = sum - m1;
		sub2 = sum - m2;
		if (sum >= m2) begin
			step = sub2[W-1:0];
		end else if (sum >= m1) begin
			step = sub1[W-1:0];
		end else begin
			step = sum[W-1:0];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= step;
			b_q   <= {b_q[W-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.busy = busy_q;
	assign prod     = acc_q;

	// checks
	`ASSERT_AR(a_no_restart, clk, arst_n, !(req.start && busy_q))
	`ASSERT_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q && !busy_q)
	`ASSERT_AR(a_prod_reduced, clk, arst_n, !done_q || (acc_q < m))

endmodule

`default_nettype wire

/* hdl/rsa_modular_exponentiation.sv */
// ----------------------------------------------------------------------------
// rsa_modular_exponentiation
// value ^ exponent mod modulus by left-to-right square-and-multiply.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes modulus (0),
//   public exponent (1) and private exponent (2); other indexes are dropped.
//   cfg_ready is always high. Write only while no item is in flight.
//   req channel (req_valid/req_stall) carries action and value; rsp channel
//   (rsp_valid/rsp_stall) returns one result per item.
// Sequence: an item first reduces value mod modulus, then runs MOD_BITS
//   squarings plus one multiply per set exponent bit, each on the shared
//   shift-add unit with a registered start and done handoff, and then loads
//   the output register. An item with zero exponent or a modulus below 2
//   skips the multiplier and goes straight to the output register.
// Flow: one item at a time; req_stall is high after the transfer until the
//   result is in the output register, and no new item is taken before then.
// Stall: the output register holds the result while rsp_stall is high; a new
//   item is accepted meanwhile, and its result waits until the register frees.
// Reset: modulus 2, both exponents 0, no item or result pending.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rsa_modular_exponentiation #(
	parameter int MOD_BITS = 24
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration writes
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire rme_pkg::cfg_idx_t    cfg_index,
	input  wire logic [MOD_BITS-1:0]  cfg_data,
	// input items
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire logic                 action,
	input  wire logic [MOD_BITS-1:0]  value,
	// results
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	output logic [MOD_BITS-1:0]       result
);

	localparam int W  = MOD_BITS;
	localparam int CW = $clog2(W);
	localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1};
	localparam logic [W-1:0] TWO = {{(W-2){1'b0}}, 2'b10};

	// configuration registers
	logic [W-1:0] modulus_q;
	logic [W-1:0] pub_exp_q;
	logic [W-1:0] priv_exp_q;

	// sequencer and operands
	rme_pkg::st_t state_q;
	rme_pkg::st_t state_d;
	logic [W-1:0]  ex_q;
	logic [CW-1:0] bcnt_q;
	logic [W-1:0]  base_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  opa_q;
	logic [W-1:0]  opb_q;
	logic          start_q;

	// output register
	logic          out_valid_q;
	logic [W-1:0]  result_q;

	rme_pkg::mm_req_t mm_req;
	rme_pkg::mm_rsp_t mm_rsp;
	logic [W-1:0]     mm_prod;

	logic          req_xfer;
	logic          out_free;
	logic [W-1:0]  sel_ex;
	logic          ex_zero;
	logic          trivial;
	logic          last_bit;

	assign cfg_ready = 1'b1;

	// configuration write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= TWO;
			pub_exp_q  <= '0;
			priv_exp_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rme_pkg::CFG_MODULUS:  modulus_q  <= cfg_data;
				rme_pkg::CFG_PUB_EXP:  pub_exp_q  <= cfg_data;
				rme_pkg::CFG_PRIV_EXP: priv_exp_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// shared modular multiplier
	assign mm_req.start = start_q;

	rme_mulmod #(
		.W(W)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.rsp    (mm_rsp),
		.a      (opa_q),
		.b      (opb_q),
		.m      (modulus_q),
		.prod   (mm_prod)
	);

	// item decode
	assign req_stall = (state_q != rme_pkg::ST_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign out_free  = !out_valid_q || !rsp_stall;
	assign sel_ex    = (action == rme_pkg::ACT_DECRYPT) ? priv_exp_q : pub_exp_q;
	assign ex_zero   = (sel_ex == '0);
	assign trivial   = ex_zero || (modulus_q < TWO);
	assign last_bit  = (bcnt_q == '0);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rme_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rme_pkg::ST_IDLE: begin
				if (req_xfer) begin
					state_d = trivial ? rme_pkg::ST_FIN : rme_pkg::ST_RED;
				end
			end
			rme_pkg::ST_RED: begin
				if (mm_rsp.done) begin
					state_d = rme_pkg::ST_SQ;
				end
			end
			rme_pkg::ST_SQ: begin
				if (mm_rsp.done) begin
					if (ex_q[W-1]) begin
						state_d = rme_pkg::ST_MUL;
					end else if (last_bit) begin
						state_d = rme_pkg::ST_FIN;
					end
				end
			end
			rme_pkg::ST_MUL: begin
				if (mm_rsp.done) begin
					state_d = last_bit ? rme_pkg::ST_FIN : rme_pkg::ST_SQ;
				end
			end
			rme_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = rme_pkg::ST_IDLE;
				end
			end
			default: state_d = rme_pkg::ST_IDLE;
		endcase
	end

	// multiplier launch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				rme_pkg::ST_IDLE: start_q <= req_xfer && !trivial;
				rme_pkg::ST_RED:  start_q <= mm_rsp.done;
				rme_pkg::ST_SQ:   start_q <= mm_rsp.done && (ex_q[W-1] || !last_bit);
				rme_pkg::ST_MUL:  start_q <= mm_rsp.done && !last_bit;
				default:          start_q <= 1'b0;
			endcase
		end
	end

	// operand and exponent registers
	always_ff @(posedge clk) begin
		case (state_q)
			rme_pkg::ST_IDLE: begin
				if (req_xfer) begin
					ex_q   <= sel_ex;
					bcnt_q <= CW'(W - 1);
					acc_q  <= ex_zero ? ONE : '0;
					// value mod m as 1 * value through the multiplier
					opa_q  <= ONE;
					opb_q  <= value;
				end
			end
			rme_pkg::ST_RED: begin
				if (mm_rsp.done) begin
					base_q <= mm_prod;
					opa_q  <= ONE;
					opb_q  <= ONE;
				end
			end
			rme_pkg::ST_SQ: begin
				if (mm_rsp.done) begin
					acc_q <= mm_prod;
					if (ex_q[W-1]) begin
						opa_q <= mm_prod;
						opb_q <= base_q;
					end else if (!last_bit) begin
						opa_q  <= mm_prod;
						opb_q  <= mm_prod;
						ex_q   <= {ex_q[W-2:0], 1'b0};
						bcnt_q <= bcnt_q - 1'b1;
					end
				end
			end
			rme_pkg::ST_MUL: begin
				if (mm_rsp.done) begin
					acc_q <= mm_prod;
					if (!last_bit) begin
						opa_q  <= mm_prod;
						opb_q  <= mm_prod;
						ex_q   <= {ex_q[W-2:0], 1'b0};
						bcnt_q <= bcnt_q - 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == rme_pkg::ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rme_pkg::ST_FIN && out_free) begin
			result_q <= acc_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign result    = result_q;

	// checks
	`ASSERT_AR(a_start_in_run, clk, arst_n,
		!start_q || state_q == rme_pkg::ST_RED || state_q == rme_pkg::ST_SQ ||
		state_q == rme_pkg::ST_MUL)
	`ASSERT_AR(a_done_in_run, clk, arst_n,
		!mm_rsp.done || state_q == rme_pkg::ST_RED || state_q == rme_pkg::ST_SQ ||
		state_q == rme_pkg::ST_MUL)
	`ASSERT_AR(a_idle_mm_quiet, clk, arst_n,
		!(state_q == rme_pkg::ST_IDLE || state_q == rme_pkg::ST_FIN) || !mm_rsp.busy)

endmodule

`default_nettype wire
